// File: rtl/lcs_pkg.sv
// Shared types and constants of the longest common substring engine.
`default_nettype none
package lcs_pkg;

  localparam int LCS_MAX_TEXT  = 4096;
  localparam int ALPHA_BUCKETS = 29;
  localparam int SYM_MAX       = 25;
  localparam int CODE_OFFSET   = 2;
  localparam int SEP_CODE      = 1;
  localparam int SENT_CODE     = 0;
  localparam int OUT_W         = 12;
  localparam int RG_W          = 3;

  // Regions of the shared work memory
  typedef enum logic [RG_W-1:0] {
    RG_TEXT, RG_SA, RG_RANK, RG_NRANK, RG_SHIFT, RG_CNT, RG_INV, RG_LCP
  } region_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_SEP, ST_SENT,
    ST_CLRA, ST_CTA_RD, ST_CTA_CNT, ST_CTA_WR,
    ST_PFX_RD0, ST_PFX_INIT, ST_PFX_RD, ST_PFX_WR,
    ST_PLA_RD, ST_PLA_CNT, ST_PLA_DEC, ST_PLA_WR,
    ST_RK0_RD, ST_RK0_TXT, ST_RK0_WR, ST_RK_RD, ST_RK_TXT, ST_RK_WR,
    ST_SH_RD, ST_SH_WR, ST_CLR,
    ST_CT_RD, ST_CT_RANK, ST_CT_CNT, ST_CT_WR,
    ST_PL_RD, ST_PL_RANK, ST_PL_CNT, ST_PL_DEC, ST_PL_WR,
    ST_NR_RD, ST_NR_RANK, ST_NR_RMA, ST_NR_WR,
    ST_CP_RD, ST_CP_WR,
    ST_INV_RD, ST_INV_WR,
    ST_K_INV, ST_K_CHK, ST_K_SA, ST_KC_CMP0, ST_KC_TI, ST_KC_CMP, ST_K_WR,
    ST_SC_RD0, ST_SC_B, ST_SC_RD, ST_SC_A, ST_SC_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } lcs_status_t;

  typedef struct packed {
    logic [OUT_W-1:0] match_length;
    logic [OUT_W-1:0] start_pos;
    logic             overflow;
  } lcs_result_t;

endpackage
`default_nettype wire

// File: rtl/lcs_mem.sv
// Shared work memory: one write port, one read port with registered data.
`default_nettype none
module lcs_mem #(
  parameter int AW = 15,
  parameter int DW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lcs_ctrl.sv
// Sequencer: loads the text, sorts suffixes, builds LCP values and scans them.
`default_nettype none
module lcs_ctrl
  import lcs_pkg::*;
#(
  parameter int MAX_TEXT = LCS_MAX_TEXT,
  parameter int IW       = 12,
  parameter int DW       = 13,
  parameter int AW       = IW + RG_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [4:0]    in_symbol,
  input  wire logic          in_second_string,
  input  wire logic          in_last,
  output logic               mem_we,
  output logic      [AW-1:0] mem_waddr,
  output logic      [DW-1:0] mem_wdata,
  output logic      [AW-1:0] mem_raddr,
  input  wire logic [DW-1:0] mem_rdata,
  input  wire logic          res_take,
  output lcs_status_t        status,
  output lcs_result_t        result
);

  state_t state_r, state_nxt;

  logic [DW-1:0] first_r, first_nxt;
  logic [DW-1:0] total_r, total_nxt;
  logic          ovf_r, ovf_nxt;
  logic [DW-1:0] len_r, len_nxt;
  logic [DW-1:0] i_r, i_nxt;
  logic [DW:0]   h_r, h_nxt;
  logic [DW-1:0] classes_r, classes_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] t_r, t_nxt;
  logic [DW-1:0] v_r, v_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] ma_r, ma_nxt;
  logic [DW-1:0] pra_r, pra_nxt;
  logic [DW-1:0] prma_r, prma_nxt;
  logic [DW-1:0] k_r, k_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] j_r, j_nxt;
  logic [DW-1:0] far_r, far_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [DW-1:0] start_r, start_nxt;
  logic          pass_r, pass_nxt;

  logic          accept;
  logic [DW-1:0] rd;
  logic [DW-1:0] len_m1;
  logic          i_last;
  logic [DW-1:0] pfx_lim;
  logic          pfx_last;
  logic          pfx_one;
  logic          alpha_last;
  logic [4:0]    sym_sat;
  logic [DW-1:0] sym_code;
  logic          room;
  logic [DW:0]   h_dbl;
  logic          h_more;
  logic [DW:0]   ma_sum;
  logic [DW-1:0] ma_wrap;
  logic [DW:0]   far_k;
  logic          cmp_go;
  logic [DW-1:0] shift_val;
  logic          nr_diff;
  logic [DW-1:0] nr_cls;
  logic          txt_diff;
  logic [DW-1:0] d1, d2, v1, v2, sc_val;
  logic          sc_upd;

  function automatic logic [AW-1:0] maddr(input region_t rg, input logic [DW-1:0] ix);
    return {rg, ix[IW-1:0]};
  endfunction

  assign rd       = mem_rdata;
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign len_m1   = len_r - DW'(1);
  assign i_last   = (i_r == len_m1);
  assign pfx_lim  = pass_r ? classes_r : DW'(ALPHA_BUCKETS);
  assign pfx_last = (i_r == pfx_lim - DW'(1));
  assign pfx_one  = (pfx_lim == DW'(1));
  assign alpha_last = (i_r == DW'(ALPHA_BUCKETS - 1));

  assign sym_sat  = (in_symbol > 5'(SYM_MAX)) ? 5'(SYM_MAX) : in_symbol;
  assign sym_code = DW'(sym_sat) + DW'(CODE_OFFSET);
  assign room     = ({1'b0, total_r} + (DW+1)'(3)) <= (DW+1)'(MAX_TEXT);

  assign h_dbl    = {h_r[DW-1:0], 1'b0};
  assign h_more   = h_dbl < {1'b0, len_r};

  assign ma_sum   = {1'b0, rd} + {1'b0, h_r[DW-1:0]};
  assign ma_wrap  = (ma_sum >= {1'b0, len_r}) ? DW'(ma_sum - {1'b0, len_r}) : DW'(ma_sum);
  assign shift_val = (rd >= h_r[DW-1:0]) ? (rd - h_r[DW-1:0])
                                         : DW'({1'b0, rd} + {1'b0, len_r} - h_r);

  assign far_k    = {1'b0, far_r} + {1'b0, k_r};
  assign cmp_go   = far_k < {1'b0, len_r};

  assign nr_diff  = (i_r != '0) && ((t_r != pra_r) || (rd != prma_r));
  assign nr_cls   = (i_r == '0) ? DW'(1) : (classes_r + DW'(nr_diff));
  assign txt_diff = (rd != t_r);

  // Scan: only pairs that straddle the separator count
  assign d1     = first_r - a_r;
  assign d2     = first_r - b_r;
  assign v1     = (rd < d1) ? rd : d1;
  assign v2     = (rd < d2) ? rd : d2;
  assign sc_val = ((a_r < first_r) && (b_r > first_r)) ? v1 :
                  ((a_r > first_r) && (b_r < first_r)) ? v2 : '0;
  assign sc_upd = sc_val > best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      first_r <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    i_r       <= i_nxt;
    h_r       <= h_nxt;
    classes_r <= classes_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    v_r       <= v_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    ma_r      <= ma_nxt;
    pra_r     <= pra_nxt;
    prma_r    <= prma_nxt;
    k_r       <= k_nxt;
    r_r       <= r_nxt;
    j_r       <= j_nxt;
    far_r     <= far_nxt;
    best_r    <= best_nxt;
    start_r   <= start_nxt;
    pass_r    <= pass_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (accept && in_last) state_nxt = ST_SEP;
      ST_SEP:      state_nxt = ST_SENT;
      ST_SENT:     state_nxt = ST_CLRA;
      ST_CLRA:     if (alpha_last) state_nxt = ST_CTA_RD;
      ST_CTA_RD:   state_nxt = ST_CTA_CNT;
      ST_CTA_CNT:  state_nxt = ST_CTA_WR;
      ST_CTA_WR:   state_nxt = i_last ? ST_PFX_RD0 : ST_CTA_RD;
      ST_PFX_RD0:  state_nxt = ST_PFX_INIT;
      ST_PFX_INIT: state_nxt = pfx_one ? (pass_r ? ST_PL_RD : ST_PLA_RD) : ST_PFX_RD;
      ST_PFX_RD:   state_nxt = ST_PFX_WR;
      ST_PFX_WR:   state_nxt = !pfx_last ? ST_PFX_RD : (pass_r ? ST_PL_RD : ST_PLA_RD);
      ST_PLA_RD:   state_nxt = ST_PLA_CNT;
      ST_PLA_CNT:  state_nxt = ST_PLA_DEC;
      ST_PLA_DEC:  state_nxt = ST_PLA_WR;
      ST_PLA_WR:   state_nxt = i_last ? ST_RK0_RD : ST_PLA_RD;
      ST_RK0_RD:   state_nxt = ST_RK0_TXT;
      ST_RK0_TXT:  state_nxt = ST_RK0_WR;
      ST_RK0_WR:   state_nxt = ST_RK_RD;
      ST_RK_RD:    state_nxt = ST_RK_TXT;
      ST_RK_TXT:   state_nxt = ST_RK_WR;
      ST_RK_WR:    state_nxt = i_last ? ST_SH_RD : ST_RK_RD;
      ST_SH_RD:    state_nxt = ST_SH_WR;
      ST_SH_WR:    state_nxt = i_last ? ST_CLR : ST_SH_RD;
      ST_CLR:      if (i_last) state_nxt = ST_CT_RD;
      ST_CT_RD:    state_nxt = ST_CT_RANK;
      ST_CT_RANK:  state_nxt = ST_CT_CNT;
      ST_CT_CNT:   state_nxt = ST_CT_WR;
      ST_CT_WR:    state_nxt = i_last ? ST_PFX_RD0 : ST_CT_RD;
      ST_PL_RD:    state_nxt = ST_PL_RANK;
      ST_PL_RANK:  state_nxt = ST_PL_CNT;
      ST_PL_CNT:   state_nxt = ST_PL_DEC;
      ST_PL_DEC:   state_nxt = ST_PL_WR;
      ST_PL_WR:    state_nxt = (i_r == '0) ? ST_NR_RD : ST_PL_RD;
      ST_NR_RD:    state_nxt = ST_NR_RANK;
      ST_NR_RANK:  state_nxt = ST_NR_RMA;
      ST_NR_RMA:   state_nxt = ST_NR_WR;
      ST_NR_WR:    state_nxt = i_last ? ST_CP_RD : ST_NR_RD;
      ST_CP_RD:    state_nxt = ST_CP_WR;
      ST_CP_WR:    state_nxt = !i_last ? ST_CP_RD : (h_more ? ST_SH_RD : ST_INV_RD);
      ST_INV_RD:   state_nxt = ST_INV_WR;
      ST_INV_WR:   state_nxt = i_last ? ST_K_INV : ST_INV_RD;
      ST_K_INV:    state_nxt = ST_K_CHK;
      ST_K_CHK:    state_nxt = (rd == len_m1) ? (i_last ? ST_SC_RD0 : ST_K_INV) : ST_K_SA;
      ST_K_SA:     state_nxt = ST_KC_CMP0;
      ST_KC_CMP0:  state_nxt = cmp_go ? ST_KC_TI : ST_K_WR;
      ST_KC_TI:    state_nxt = ST_KC_CMP;
      ST_KC_CMP:   state_nxt = (rd == t_r) ? ST_KC_CMP0 : ST_K_WR;
      ST_K_WR:     state_nxt = i_last ? ST_SC_RD0 : ST_K_INV;
      ST_SC_RD0:   state_nxt = ST_SC_B;
      ST_SC_B:     state_nxt = ST_SC_RD;
      ST_SC_RD:    state_nxt = ST_SC_A;
      ST_SC_A:     state_nxt = ST_SC_EVAL;
      ST_SC_EVAL:  state_nxt = i_last ? ST_DONE : ST_SC_RD;
      ST_DONE:     if (res_take) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory accesses and datapath registers
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = maddr(RG_TEXT, '0);
    mem_wdata   = '0;
    mem_raddr   = maddr(RG_TEXT, '0);
    first_nxt   = first_r;
    total_nxt   = total_r;
    ovf_nxt     = ovf_r;
    len_nxt     = len_r;
    i_nxt       = i_r;
    h_nxt       = h_r;
    classes_nxt = classes_r;
    acc_nxt     = acc_r;
    t_nxt       = t_r;
    v_nxt       = v_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    ma_nxt      = ma_r;
    pra_nxt     = pra_r;
    prma_nxt    = prma_r;
    k_nxt       = k_r;
    r_nxt       = r_r;
    j_nxt       = j_r;
    far_nxt     = far_r;
    best_nxt    = best_r;
    start_nxt   = start_r;
    pass_nxt    = pass_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_second_string) begin
            // first string letters after second string letters are ignored
            if (total_r == first_r) begin
              if (room) begin
                mem_we    = 1'b1;
                mem_waddr = maddr(RG_TEXT, first_r);
                mem_wdata = sym_code;
                first_nxt = first_r + DW'(1);
                total_nxt = total_r + DW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end else if (room) begin
            mem_we    = 1'b1;
            mem_waddr = maddr(RG_TEXT, total_r + DW'(1));
            mem_wdata = sym_code;
            total_nxt = total_r + DW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_SEP: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_TEXT, first_r);
        mem_wdata = DW'(SEP_CODE);
        len_nxt   = total_r + DW'(2);
      end
      ST_SENT: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_TEXT, len_m1);
        mem_wdata = DW'(SENT_CODE);
        i_nxt     = '0;
      end
      ST_CLRA: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, i_r);
        i_nxt     = alpha_last ? '0 : i_r + DW'(1);
      end
      ST_CTA_RD:  mem_raddr = maddr(RG_TEXT, i_r);
      ST_CTA_CNT: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_CNT, rd);
      end
      ST_CTA_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, t_r);
        mem_wdata = rd + DW'(1);
        i_nxt     = i_r + DW'(1);
        pass_nxt  = 1'b0;
      end
      ST_PFX_RD0: mem_raddr = maddr(RG_CNT, '0);
      ST_PFX_INIT: begin
        acc_nxt = rd;
        i_nxt   = pfx_one ? (pass_r ? len_m1 : '0) : DW'(1);
      end
      ST_PFX_RD: mem_raddr = maddr(RG_CNT, i_r);
      ST_PFX_WR: begin
        acc_nxt   = acc_r + rd;
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, i_r);
        mem_wdata = acc_r + rd;
        i_nxt     = !pfx_last ? i_r + DW'(1) : (pass_r ? len_m1 : '0);
      end
      ST_PLA_RD:  mem_raddr = maddr(RG_TEXT, i_r);
      ST_PLA_CNT: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_CNT, rd);
      end
      ST_PLA_DEC: begin
        v_nxt     = rd - DW'(1);
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, t_r);
        mem_wdata = rd - DW'(1);
      end
      ST_PLA_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_SA, v_r);
        mem_wdata = i_r;
        i_nxt     = i_r + DW'(1);
      end
      ST_RK0_RD:  mem_raddr = maddr(RG_SA, '0);
      ST_RK0_TXT: begin
        a_nxt     = rd;
        mem_raddr = maddr(RG_TEXT, rd);
      end
      ST_RK0_WR: begin
        t_nxt       = rd;
        mem_we      = 1'b1;
        mem_waddr   = maddr(RG_RANK, a_r);
        classes_nxt = DW'(1);
        i_nxt       = DW'(1);
      end
      ST_RK_RD:  mem_raddr = maddr(RG_SA, i_r);
      ST_RK_TXT: begin
        a_nxt     = rd;
        mem_raddr = maddr(RG_TEXT, rd);
      end
      ST_RK_WR: begin
        classes_nxt = classes_r + DW'(txt_diff);
        t_nxt       = rd;
        mem_we      = 1'b1;
        mem_waddr   = maddr(RG_RANK, a_r);
        mem_wdata   = classes_r + DW'(txt_diff) - DW'(1);
        i_nxt       = i_last ? '0 : i_r + DW'(1);
        if (i_last) begin
          h_nxt = (DW+1)'(1);
        end
      end
      ST_SH_RD: mem_raddr = maddr(RG_SA, i_r);
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_SHIFT, i_r);
        mem_wdata = shift_val;
        i_nxt     = i_last ? '0 : i_r + DW'(1);
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, i_r);
        i_nxt     = i_last ? '0 : i_r + DW'(1);
      end
      ST_CT_RD:   mem_raddr = maddr(RG_SHIFT, i_r);
      ST_CT_RANK: mem_raddr = maddr(RG_RANK, rd);
      ST_CT_CNT: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_CNT, rd);
      end
      ST_CT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, t_r);
        mem_wdata = rd + DW'(1);
        i_nxt     = i_r + DW'(1);
        pass_nxt  = 1'b1;
      end
      // Place from the top down to keep the sort stable
      ST_PL_RD:   mem_raddr = maddr(RG_SHIFT, i_r);
      ST_PL_RANK: begin
        a_nxt     = rd;
        mem_raddr = maddr(RG_RANK, rd);
      end
      ST_PL_CNT: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_CNT, rd);
      end
      ST_PL_DEC: begin
        v_nxt     = rd - DW'(1);
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_CNT, t_r);
        mem_wdata = rd - DW'(1);
      end
      ST_PL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_SA, v_r);
        mem_wdata = a_r;
        i_nxt     = (i_r == '0) ? '0 : i_r - DW'(1);
      end
      ST_NR_RD:   mem_raddr = maddr(RG_SA, i_r);
      ST_NR_RANK: begin
        a_nxt     = rd;
        ma_nxt    = ma_wrap;
        mem_raddr = maddr(RG_RANK, rd);
      end
      ST_NR_RMA: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_RANK, ma_r);
      end
      ST_NR_WR: begin
        // ranks of this pair become the previous pair for the next element
        classes_nxt = nr_cls;
        mem_we      = 1'b1;
        mem_waddr   = maddr(RG_NRANK, a_r);
        mem_wdata   = nr_cls - DW'(1);
        pra_nxt     = t_r;
        prma_nxt    = rd;
        i_nxt       = i_last ? '0 : i_r + DW'(1);
      end
      ST_CP_RD: mem_raddr = maddr(RG_NRANK, i_r);
      ST_CP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_RANK, i_r);
        mem_wdata = rd;
        i_nxt     = i_last ? '0 : i_r + DW'(1);
        if (i_last) begin
          h_nxt = h_dbl;
        end
      end
      ST_INV_RD: mem_raddr = maddr(RG_SA, i_r);
      ST_INV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_INV, rd);
        mem_wdata = i_r;
        i_nxt     = i_last ? '0 : i_r + DW'(1);
        k_nxt     = '0;
      end
      ST_K_INV: begin
        if (k_r != '0) begin
          k_nxt = k_r - DW'(1);
        end
        mem_raddr = maddr(RG_INV, i_r);
      end
      ST_K_CHK: begin
        r_nxt = rd;
        if (rd == len_m1) begin
          mem_we    = 1'b1;
          mem_waddr = maddr(RG_LCP, len_m1);
          k_nxt     = '0;
          i_nxt     = i_r + DW'(1);
        end else begin
          mem_raddr = maddr(RG_SA, rd + DW'(1));
        end
      end
      ST_K_SA: begin
        j_nxt   = rd;
        far_nxt = (i_r > rd) ? i_r : rd;
      end
      ST_KC_CMP0: if (cmp_go) mem_raddr = maddr(RG_TEXT, i_r + k_r);
      ST_KC_TI: begin
        t_nxt     = rd;
        mem_raddr = maddr(RG_TEXT, j_r + k_r);
      end
      ST_KC_CMP: if (rd == t_r) k_nxt = k_r + DW'(1);
      ST_K_WR: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(RG_LCP, r_r);
        mem_wdata = k_r;
        i_nxt     = i_r + DW'(1);
      end
      ST_SC_RD0: mem_raddr = maddr(RG_SA, '0);
      ST_SC_B: begin
        b_nxt    = rd;
        best_nxt = '0;
        i_nxt    = DW'(1);
      end
      ST_SC_RD: mem_raddr = maddr(RG_SA, i_r);
      ST_SC_A: begin
        a_nxt     = rd;
        mem_raddr = maddr(RG_LCP, i_r - DW'(1));
      end
      ST_SC_EVAL: begin
        if (sc_upd) begin
          best_nxt = sc_val;
        end
        if (sc_upd || (i_r == DW'(1))) begin
          start_nxt = a_r;
        end
        b_nxt = a_r;
        i_nxt = i_r + DW'(1);
      end
      ST_DONE: begin
        if (res_take) begin
          first_nxt = '0;
          total_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status.idle          = (state_r == ST_IDLE);
  assign status.res_valid     = (state_r == ST_DONE);
  assign result.match_length  = OUT_W'(best_r);
  assign result.start_pos     = OUT_W'(start_r);
  assign result.overflow      = ovf_r;

`ifndef SYNTHESIS
  a_total_ge_first: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= first_r)
    else $error("second string count went below first string count");

  a_best_in_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (best_r <= first_r))
    else $error("match longer than the first string");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KC_CMP0) |-> (k_r <= len_r))
    else $error("prefix match ran past the text");

  a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && !res_take) |=> (state_r == ST_DONE))
    else $error("result dropped before it was taken");
`endif

endmodule
`default_nettype wire

// File: rtl/longest_common_substring_engine.sv
// Longest common substring engine: top level with result register.
//
// Input channel (in_valid / in_stall): one symbol per item, first string,
// then second string; in_last marks the final symbol and starts the search.
// Symbols are taken one per cycle while the engine is loading. After the
// final item in_stall stays high until the output register takes the result.
// Result channel (out_valid / out_stall): one item per final symbol with the
// match length, the start in the combined text and the overflow flag.
// Compute time after the final item depends on L = combined length
// (letters + 2) and P = ceil(log2 L) doubling passes, and grows with
// every matching symbol pair in the LCP pass. Each step makes at most
// one access to the single shared work memory (one write or one read,
// with registered read data).
// The result waits in an output register; the engine returns to loading
// at once when that register is free, and holds its result while the
// receiver stalls and the register is still occupied.
// Reset clears the control state and counters; memory contents are kept
// only as scratch and are always written before they are read.
`default_nettype none
module longest_common_substring_engine
  import lcs_pkg::*;
#(
  parameter int MAX_TEXT = LCS_MAX_TEXT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [4:0]       in_symbol,
  input  wire logic             in_second_string,
  input  wire logic             in_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [OUT_W-1:0] out_match_length,
  output logic      [OUT_W-1:0] out_start_pos,
  output logic                  out_overflow
);

  localparam int REG_DEPTH = (MAX_TEXT > 32) ? MAX_TEXT : 32;
  localparam int IW        = $clog2(REG_DEPTH);
  localparam int DW0       = $clog2(MAX_TEXT + 1);
  localparam int DW        = (DW0 > 5) ? DW0 : 5;
  localparam int AW        = IW + RG_W;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  lcs_status_t   status;
  lcs_result_t   result;
  logic          res_take;

  logic        out_valid_r, out_valid_nxt;
  lcs_result_t out_r, out_nxt;

  lcs_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lcs_ctrl #(.MAX_TEXT(MAX_TEXT), .IW(IW), .DW(DW), .AW(AW)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_symbol        (in_symbol),
    .in_second_string (in_second_string),
    .in_last          (in_last),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .res_take         (res_take),
    .status           (status),
    .result           (result)
  );

  assign in_stall = !status.idle;

  // Load the result register when it is empty or being drained
  assign res_take = status.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_r.match_length;
  assign out_start_pos    = out_r.start_pos;
  assign out_overflow     = out_r.overflow;

endmodule
`default_nettype wire
